/* hw/rtl/tlfq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfq_pkg
// Shared types and constants of the three-level feedback queue scheduler.
// ----------------------------------------------------------------------------
package tlfq_pkg;

    // Fixed field widths of the ports
    localparam int JOB_W       = 4;
    localparam int ARR_BURST_W = 10;
    localparam int QUANTUM_W   = 8;
    localparam int LEVEL_W     = 2;
    localparam int CFG_IDX_W   = 1;

    // Queue levels as reported on the result
    localparam logic [LEVEL_W-1:0] LVL_TOP  = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_MID  = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_FCFS = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM1 = 1'b1;

    // Register reset values
    localparam logic [QUANTUM_W-1:0] QUANTUM0_RST = 8'd2;
    localparam logic [QUANTUM_W-1:0] QUANTUM1_RST = 8'd4;

    // Per-level queue control for one tick
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

endpackage

/* hw/rtl/tlfq_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfq_queue
// Circular job-id queue for one priority level: head pointer, occupancy
// count and slot storage. One push and one pop per cycle.
// ----------------------------------------------------------------------------
module tlfq_queue #(
    parameter int DEPTH = 16,
    parameter int IDW   = 4,
    parameter int CNTW  = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tlfq_pkg::t_q_ctrl     i_ctrl,
    input  logic [IDW-1:0]        i_push_id,
    output logic [CNTW-1:0]       o_count,
    output logic [IDW-1:0]        o_head_id
);
    import tlfq_pkg::*;

    localparam int SW = IDW + 1;

    logic [IDW-1:0]  r_slot [DEPTH];
    logic [IDW-1:0]  r_head;
    logic [IDW-1:0]  n_head;
    logic [CNTW-1:0] r_count;
    logic [CNTW-1:0] n_count;
    logic [SW-1:0]   tail_sum;
    logic [IDW-1:0]  tail;

    // Tail slot: head + count, wrapped once
    always_comb begin
        tail_sum = SW'(r_head) + SW'(r_count);
        if (tail_sum >= SW'(DEPTH)) begin
            tail = IDW'(tail_sum - SW'(DEPTH));
        end else begin
            tail = IDW'(tail_sum);
        end
    end

    // Head advance and occupancy
    always_comb begin
        n_head = r_head;
        if (i_ctrl.pop) begin
            if (r_head == IDW'(DEPTH - 1)) begin
                n_head = '0;
            end else begin
                n_head = r_head + IDW'(1);
            end
        end
        n_count = r_count + CNTW'(i_ctrl.push) - CNTW'(i_ctrl.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Slot storage, no reset: only occupied slots are read
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_slot[tail] <= i_push_id;
        end
    end

    assign o_count   = r_count;
    assign o_head_id = r_slot[r_head];

endmodule

/* hw/rtl/three_level_feedback_queue_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_feedback_queue_scheduler
// Three-level feedback queue scheduler stepped once per tick: two round-robin
// levels with demotion and an FCFS bottom level.
// ----------------------------------------------------------------------------
// One tick is issued by raising start for one cycle; a tick can be issued in
// every cycle and busy is only high during reset. The tick is latched in an
// input register, the whole arrival/schedule/update step runs in the
// following cycle, and its result is captured in a result register before it
// appears on the o_ ports, with o_strobe high for exactly one cycle. There is no
// back-pressure: the receiver must take every result in the cycle it is shown.
// Quantum registers may only be written while no tick is in flight.
// ----------------------------------------------------------------------------
module three_level_feedback_queue_scheduler #(
    parameter int MAX_JOBS   = 16,
    parameter int BURST_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_arrival_valid,
    input  logic [tlfq_pkg::JOB_W-1:0]          i_arrival_job,
    input  logic [tlfq_pkg::ARR_BURST_W-1:0]    i_arrival_burst,
    input  logic                                i_cfg_we,
    input  logic [tlfq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tlfq_pkg::QUANTUM_W-1:0]      i_cfg_data,
    output logic                                o_strobe,
    output logic                                o_ran_valid,
    output logic [tlfq_pkg::JOB_W-1:0]          o_ran_job,
    output logic [tlfq_pkg::LEVEL_W-1:0]        o_ran_level,
    output logic                                o_job_completed,
    output logic                                o_job_demoted,
    output logic                                o_queue_overflow
);
    import tlfq_pkg::*;

    localparam int IDW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNTW = $clog2(MAX_JOBS + 1);
    localparam int BW   = BURST_BITS;
    localparam int CW   = (BW > ARR_BURST_W) ? BW : ARR_BURST_W;
    localparam int QCW  = (BW > QUANTUM_W) ? BW : QUANTUM_W;
    localparam logic [BW-1:0]   BURST_MAX = '1;
    localparam logic [CNTW-1:0] FULL_CNT  = CNTW'(MAX_JOBS);

    // Job id modulo MAX_JOBS as a small constant table
    function automatic logic [IDW-1:0] job_mod(input logic [JOB_W-1:0] v);
        logic [IDW-1:0] res;
        res = '0;
        for (int k = 0; k < (1 << JOB_W); k++) begin
            if (v == JOB_W'(k)) begin
                res = IDW'(k % MAX_JOBS);
            end
        end
        return res;
    endfunction

    // Saturate the arriving burst to BURST_BITS
    function automatic logic [BW-1:0] burst_sat(input logic [ARR_BURST_W-1:0] v);
        logic [BW-1:0] res;
        if (CW'(v) > CW'(BURST_MAX)) begin
            res = BURST_MAX;
        end else begin
            res = BW'(v);
        end
        return res;
    endfunction

    // Quantum on entry to a level: min(max(reg, 1), remaining burst)
    function automatic logic [QUANTUM_W-1:0] first_q(input logic [QUANTUM_W-1:0] reg_q,
                                                     input logic [BW-1:0] burst);
        logic [QUANTUM_W-1:0] q;
        logic [QUANTUM_W-1:0] res;
        q = (reg_q == '0) ? QUANTUM_W'(1) : reg_q;
        if (QCW'(q) < QCW'(burst)) begin
            res = q;
        end else begin
            res = QUANTUM_W'(burst);
        end
        return res;
    endfunction

    // Input register
    logic                   r_in_valid;
    logic                   r_arr_valid;
    logic [JOB_W-1:0]       r_arr_job;
    logic [ARR_BURST_W-1:0] r_arr_burst;

    // Configuration
    logic [QUANTUM_W-1:0]   r_quantum0;
    logic [QUANTUM_W-1:0]   r_quantum1;

    // Per-job state, no reset: only ids that were enqueued are read
    logic [BW-1:0]          r_burst_left   [MAX_JOBS];
    logic [QUANTUM_W-1:0]   r_quantum_left [MAX_JOBS];

    // Queue interface
    t_q_ctrl                q_ctrl    [3];
    logic [IDW-1:0]         q_push_id [3];
    logic [CNTW-1:0]        q_count   [3];
    logic [IDW-1:0]         q_head_id [3];

    // Step logic
    logic [IDW-1:0]         aid;
    logic [BW-1:0]          ab;
    logic                   arr_try;
    logic                   arr_push;
    logic                   overflow;
    logic [QUANTUM_W-1:0]   fq0;
    logic                   run_valid;
    logic [LEVEL_W-1:0]     lv;
    logic [IDW-1:0]         id;
    logic                   bypass;
    logic [BW-1:0]          b_cur;
    logic [QUANTUM_W-1:0]   q_cur;
    logic [BW-1:0]          b_dec;
    logic [QUANTUM_W-1:0]   q_dec;
    logic [QUANTUM_W-1:0]   q_new;
    logic                   done;
    logic                   demote;

    // Result register
    logic                   r_strobe;
    logic                   r_ran_valid;
    logic [JOB_W-1:0]       r_ran_job;
    logic [LEVEL_W-1:0]     r_ran_level;
    logic                   r_job_completed;
    logic                   r_job_demoted;
    logic                   r_queue_overflow;

    assign busy = ~i_rst_n;

    // Tick capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_arr_valid <= i_arrival_valid;
            r_arr_job   <= i_arrival_job;
            r_arr_burst <= i_arrival_burst;
        end
    end

    // Quantum registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum0 <= QUANTUM0_RST;
            r_quantum1 <= QUANTUM1_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QUANTUM0: r_quantum0 <= i_cfg_data;
                CFG_QUANTUM1: r_quantum1 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Arrival: enqueue at level 0 before scheduling
    always_comb begin
        aid      = job_mod(r_arr_job);
        ab       = burst_sat(r_arr_burst);
        arr_try  = r_in_valid && r_arr_valid && (ab != '0);
        arr_push = arr_try && (q_count[0] != FULL_CNT);
        overflow = arr_try && (q_count[0] == FULL_CNT);
        fq0      = first_q(r_quantum0, ab);
    end

    // Pick the highest nonempty level and its head job
    always_comb begin
        run_valid = r_in_valid;
        lv        = LVL_TOP;
        id        = q_head_id[0];
        priority if ((q_count[0] != '0) || arr_push) begin
            lv = LVL_TOP;
            id = (q_count[0] == '0) ? aid : q_head_id[0];
        end else if (q_count[1] != '0) begin
            lv = LVL_MID;
            id = q_head_id[1];
        end else if (q_count[2] != '0) begin
            lv = LVL_FCFS;
            id = q_head_id[2];
        end else begin
            run_valid = 1'b0;
        end
    end

    // Run one tick, decide completion or demotion
    always_comb begin
        bypass = arr_push && (id == aid);
        b_cur  = bypass ? ab  : r_burst_left[id];
        q_cur  = bypass ? fq0 : r_quantum_left[id];
        b_dec  = (b_cur == '0) ? '0 : b_cur - BW'(1);
        q_dec  = (q_cur == '0) ? '0 : q_cur - QUANTUM_W'(1);
        done   = run_valid && (b_dec == '0);
        demote = run_valid && !done && (lv != LVL_FCFS) && (q_dec == '0);
        q_new  = (demote && (lv == LVL_TOP)) ? first_q(r_quantum1, b_dec) : q_dec;
    end

    // Queue controls
    always_comb begin
        q_ctrl[0].push = arr_push;
        q_ctrl[0].pop  = (done || demote) && (lv == LVL_TOP);
        q_ctrl[1].push = demote && (lv == LVL_TOP) && (q_count[1] != FULL_CNT);
        q_ctrl[1].pop  = (done || demote) && (lv == LVL_MID);
        q_ctrl[2].push = demote && (lv == LVL_MID) && (q_count[2] != FULL_CNT);
        q_ctrl[2].pop  = done && (lv == LVL_FCFS);
        q_push_id[0]   = aid;
        q_push_id[1]   = id;
        q_push_id[2]   = id;
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_level
            tlfq_queue #(
                .DEPTH (MAX_JOBS),
                .IDW   (IDW),
                .CNTW  (CNTW)
            ) u_queue (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (q_ctrl[g]),
                .i_push_id (q_push_id[g]),
                .o_count   (q_count[g]),
                .o_head_id (q_head_id[g])
            );
        end
    endgenerate

    // Job table: arrival write, unless the running job has the same id, and the running job's update
    always_ff @(posedge i_clk) begin
        if (arr_push && !(run_valid && (id == aid))) begin
            r_burst_left[aid]   <= ab;
            r_quantum_left[aid] <= fq0;
        end
        if (run_valid) begin
            r_burst_left[id]    <= b_dec;
            r_quantum_left[id]  <= q_new;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_ran_valid      <= run_valid;
            r_ran_job        <= run_valid ? JOB_W'(id) : '0;
            r_ran_level      <= run_valid ? lv : LVL_TOP;
            r_job_completed  <= done;
            r_job_demoted    <= demote;
            r_queue_overflow <= overflow;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_ran_valid      = r_ran_valid;
    assign o_ran_job        = r_ran_job;
    assign o_ran_level      = r_ran_level;
    assign o_job_completed  = r_job_completed;
    assign o_job_demoted    = r_job_demoted;
    assign o_queue_overflow = r_queue_overflow;

    // Every transfer is followed by a result strobe
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_strobe)
        else $error("tick transfer without a result");

    // An idle tick reports nothing but a possible overflow
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_ran_valid) |->
            (!o_job_completed && !o_job_demoted && (o_ran_job == '0)
             && (o_ran_level == LVL_TOP)))
        else $error("idle tick reports a job");

    // The FCFS level never demotes, and completion excludes demotion
    a_demote_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_job_demoted) |-> ((o_ran_level != LVL_FCFS) && !o_job_completed))
        else $error("bad demotion");

    // Every queue's occupancy stays within the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_count[0] <= FULL_CNT) && (q_count[1] <= FULL_CNT) && (q_count[2] <= FULL_CNT))
        else $error("queue count beyond depth");

endmodule
